// ===== rtl/dcsm_pkg.sv =====
package dcsm_pkg;

   localparam int unsigned VALUE_WIDTH     = 16;
   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned HISTORY_MAX     = 16;
   localparam int unsigned BUTTON_MAX      = 16;
   localparam int unsigned COUNT_WIDTH     = 5;
   localparam int unsigned DWELL_WIDTH     = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [1:0] {
      OP_PLANNER  = 2'd0,
      OP_TRACKER  = 2'd1,
      OP_JOYSTICK = 2'd2,
      OP_TICK     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_STOP      = 2'd0,
      KIND_DRIVE     = 2'd1,
      KIND_LOW_LEVEL = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      MODE_AUTO   = 3'b001,
      MODE_ARMING = 3'b010,
      MODE_JOY    = 3'b100
   } mode_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOGGLE_BUTTON = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_DWELL    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STABILITY     = 2'd2;

   localparam logic signed [COUNT_WIDTH-1:0] TOGGLE_BUTTON_RESET = 5'sd5;
   localparam logic [DWELL_WIDTH-1:0]        STOP_DWELL_RESET    = 16'd300;
   localparam logic [COUNT_WIDTH-1:0]        STABILITY_RESET     = 5'd5;

   typedef struct packed {
      opcode_type                    opcode;
      logic [TIME_WIDTH-1:0]         time_ms;
      logic signed [VALUE_WIDTH-1:0] first_value;
      logic signed [VALUE_WIDTH-1:0] second_value;
      logic                          solver_ok;
      logic [BUTTON_MAX-1:0]         buttons;
      logic [COUNT_WIDTH-1:0]        button_count;
      logic                          trailing;
   } req_item_type;

   typedef struct packed {
      kind_type                      command_kind;
      logic signed [VALUE_WIDTH-1:0] out_first;
      logic signed [VALUE_WIDTH-1:0] out_second;
   } rsp_item_type;

endpackage

// ===== rtl/dcsm_in_stage.sv =====
module dcsm_in_stage
   import dcsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         out_busy,
   output logic         go,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   // advance the held transaction whenever the result register can take it
   assign go        = valid_ff && !out_busy;
   assign req_stall = valid_ff && !go;
   assign accept    = req_valid && !req_stall;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (go) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/dcsm_core.sv =====
module dcsm_core
   import dcsm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       go,
   input  req_item_type               item,
   output logic                       res_valid,
   output rsp_item_type               res
);

   logic signed [COUNT_WIDTH-1:0] toggle_button_ff;
   logic [DWELL_WIDTH-1:0]        stop_dwell_ff;
   logic [COUNT_WIDTH-1:0]        stability_ff;

   mode_type                      mode_ff, mode_in;
   logic [TIME_WIDTH-1:0]         deadline_ff, deadline_in;
   logic [HISTORY_MAX-1:0]        history_ff, history_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          planner_seen_ff, planner_seen_in;
   logic [VALUE_WIDTH-1:0]        duty_ff, duty_in;
   logic [VALUE_WIDTH-1:0]        servo_ff, servo_in;
   logic                          tracker_seen_ff, tracker_seen_in;
   logic [VALUE_WIDTH-1:0]        steer_ff, steer_in;
   logic [VALUE_WIDTH-1:0]        speed_ff, speed_in;
   logic                          joy_seen_ff, joy_seen_in;
   logic [BUTTON_MAX-1:0]         prev_buttons_ff, prev_buttons_in;
   logic [COUNT_WIDTH-1:0]        prev_count_ff, prev_count_in;

   logic [COUNT_WIDTH-1:0]        eff_length;
   logic [HISTORY_MAX-1:0]        hist_mask;
   logic                          stable;
   logic [COUNT_WIDTH-1:0]        count_step;
   logic                          cur_pressed;
   logic                          prv_pressed;
   logic [TIME_WIDTH-1:0]         elapsed;

   function automatic logic button_hit(input logic [BUTTON_MAX-1:0] bits,
                                       input logic [COUNT_WIDTH-1:0] count,
                                       input logic signed [COUNT_WIDTH-1:0] idx);
      logic [COUNT_WIDTH-1:0] cnt_sat;
      logic [3:0]             pos;
      cnt_sat = (count > COUNT_WIDTH'(BUTTON_MAX)) ? COUNT_WIDTH'(BUTTON_MAX) : count;
      pos     = idx[3:0];
      return !idx[COUNT_WIDTH-1] && ({1'b0, pos} < cnt_sat) && bits[pos];
   endfunction

   assign eff_length = (stability_ff > COUNT_WIDTH'(HISTORY_MAX)) ?
                       COUNT_WIDTH'(HISTORY_MAX) : stability_ff;
   assign hist_mask  = HISTORY_MAX'(({{HISTORY_MAX{1'b0}}, 1'b1} << count_ff)
                       - {{HISTORY_MAX{1'b0}}, 1'b1});
   assign stable     = planner_seen_ff && (count_ff >= eff_length)
                       && ((history_ff & hist_mask) == hist_mask);
   assign count_step = (count_ff < COUNT_WIDTH'(HISTORY_MAX)) ?
                       count_ff + COUNT_WIDTH'(1) : count_ff;
   assign cur_pressed = button_hit(item.buttons, item.button_count, toggle_button_ff);
   assign prv_pressed = button_hit(prev_buttons_ff, prev_count_ff, toggle_button_ff);
   // wrap-aware: still inside the dwell while this difference is negative
   assign elapsed    = item.time_ms - deadline_ff;

   always_comb begin
      mode_in         = mode_ff;
      deadline_in     = deadline_ff;
      history_in      = history_ff;
      count_in        = count_ff;
      planner_seen_in = planner_seen_ff;
      duty_in         = duty_ff;
      servo_in        = servo_ff;
      tracker_seen_in = tracker_seen_ff;
      steer_in        = steer_ff;
      speed_in        = speed_ff;
      joy_seen_in     = joy_seen_ff;
      prev_buttons_in = prev_buttons_ff;
      prev_count_in   = prev_count_ff;
      res_valid       = 1'b0;
      res.command_kind = KIND_STOP;
      res.out_first    = '0;
      res.out_second   = '0;
      if (go) begin
         unique case (item.opcode)
            OP_PLANNER: begin
               duty_in         = item.first_value;
               servo_in        = item.second_value;
               planner_seen_in = 1'b1;
               history_in      = {history_ff[HISTORY_MAX-2:0], item.solver_ok};
               // drop the oldest entry when the window is over length
               count_in = (count_step > eff_length) ? count_step - COUNT_WIDTH'(1)
                                                    : count_step;
            end
            OP_TRACKER: begin
               steer_in        = item.first_value;
               speed_in        = item.second_value;
               tracker_seen_in = 1'b1;
            end
            OP_JOYSTICK: begin
               if (joy_seen_ff && cur_pressed && !prv_pressed) begin
                  if (mode_ff == MODE_JOY || mode_ff == MODE_ARMING) begin
                     mode_in = MODE_AUTO;
                  end else begin
                     mode_in     = MODE_ARMING;
                     deadline_in = item.time_ms + TIME_WIDTH'(stop_dwell_ff);
                  end
               end
               joy_seen_in     = 1'b1;
               prev_buttons_in = item.buttons;
               prev_count_in   = item.button_count;
            end
            OP_TICK: begin
               unique case (mode_ff)
                  MODE_ARMING: begin
                     if (elapsed[TIME_WIDTH-1]) begin
                        res_valid = 1'b1;
                     end else begin
                        mode_in = MODE_JOY;
                     end
                  end
                  MODE_JOY: begin
                     res_valid = 1'b0;
                  end
                  default: begin
                     if (!item.trailing && stable) begin
                        res_valid        = 1'b1;
                        res.command_kind = KIND_LOW_LEVEL;
                        res.out_first    = duty_ff;
                        res.out_second   = servo_ff;
                     end else if (tracker_seen_ff) begin
                        res_valid        = 1'b1;
                        res.command_kind = KIND_DRIVE;
                        res.out_first    = steer_ff;
                        res.out_second   = speed_ff;
                     end
                  end
               endcase
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_button_ff <= TOGGLE_BUTTON_RESET;
         stop_dwell_ff    <= STOP_DWELL_RESET;
         stability_ff     <= STABILITY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TOGGLE_BUTTON: toggle_button_ff <= csr_write_data[COUNT_WIDTH-1:0];
            CSR_STOP_DWELL:    stop_dwell_ff    <= csr_write_data[DWELL_WIDTH-1:0];
            CSR_STABILITY:     stability_ff     <= csr_write_data[COUNT_WIDTH-1:0];
            default:           stability_ff     <= stability_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_AUTO;
         history_ff      <= '0;
         count_ff        <= '0;
         planner_seen_ff <= 1'b0;
         tracker_seen_ff <= 1'b0;
         joy_seen_ff     <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         history_ff      <= history_in;
         count_ff        <= count_in;
         planner_seen_ff <= planner_seen_in;
         tracker_seen_ff <= tracker_seen_in;
         joy_seen_ff     <= joy_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff     <= deadline_in;
      duty_ff         <= duty_in;
      servo_ff        <= servo_in;
      steer_ff        <= steer_in;
      speed_ff        <= speed_in;
      prev_buttons_ff <= prev_buttons_in;
      prev_count_ff   <= prev_count_in;
   end

   a_result_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (go && item.opcode == OP_TICK))
      else $error("result produced for a non-tick transaction");

   a_low_level_needs_planner: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.command_kind == KIND_LOW_LEVEL) |-> planner_seen_ff)
      else $error("planner command issued before any planner sample");

   a_joy_from_arming: assert property (@(posedge clock) disable iff (reset)
      $rose(mode_ff == MODE_JOY) |-> $past(mode_ff == MODE_ARMING))
      else $error("joystick mode entered without stop dwell");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (go && item.opcode == OP_PLANNER) |=> (count_ff <= COUNT_WIDTH'(HISTORY_MAX)))
      else $error("history count out of range");

endmodule

// ===== rtl/dcsm_out_stage.sv =====
module dcsm_out_stage
   import dcsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic         res_valid,
   input  rsp_item_type res,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   output logic         out_busy
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   logic         load;

   assign load      = go && res_valid;
   assign out_busy  = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= res;
      end
   end

endmodule

// ===== rtl/drive_command_source_mux_unit.sv =====
// Drive command source mux: picks which drive command, if any, goes out on each
// loop tick (opcode 3) from the latest planner and tracker samples, with a
// joystick button toggling between auto and a stop-dwell/joystick mode. Planner,
// tracker and joystick transactions only update state and produce no response.
// One transaction is accepted per cycle while req_stall is low; each passes an
// input register, combinational selection logic and a result register that
// drives rsp_valid, and the response is taken on a clock edge with rsp_stall low.
// req_stall rises only while both registers are held by a stalled response.
// Configuration writes must be issued while idle.
module drive_command_source_mux_unit
   import dcsm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_opcode,
   input  logic [TIME_WIDTH-1:0]         req_time_ms,
   input  logic signed [VALUE_WIDTH-1:0] req_first_value,
   input  logic signed [VALUE_WIDTH-1:0] req_second_value,
   input  logic                          req_solver_ok,
   input  logic [BUTTON_MAX-1:0]         req_buttons,
   input  logic [COUNT_WIDTH-1:0]        req_button_count,
   input  logic                          req_trailing,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_command_kind,
   output logic signed [VALUE_WIDTH-1:0] rsp_out_first,
   output logic signed [VALUE_WIDTH-1:0] rsp_out_second
);

   req_item_type req_item;
   req_item_type item;
   rsp_item_type res;
   rsp_item_type rsp_item;
   logic         go;
   logic         out_busy;
   logic         res_valid;

   assign req_item.opcode       = opcode_type'(req_opcode);
   assign req_item.time_ms      = req_time_ms;
   assign req_item.first_value  = req_first_value;
   assign req_item.second_value = req_second_value;
   assign req_item.solver_ok    = req_solver_ok;
   assign req_item.buttons      = req_buttons;
   assign req_item.button_count = req_button_count;
   assign req_item.trailing     = req_trailing;

   assign rsp_command_kind = rsp_item.command_kind;
   assign rsp_out_first    = rsp_item.out_first;
   assign rsp_out_second   = rsp_item.out_second;

   dcsm_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .out_busy  (out_busy),
      .go        (go),
      .item      (item)
   );

   dcsm_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .go               (go),
      .item             (item),
      .res_valid        (res_valid),
      .res              (res)
   );

   dcsm_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .res_valid (res_valid),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .out_busy  (out_busy)
   );

endmodule

// ===== tb/drive_command_checker.sv =====
`timescale 1ns / 100ps

module drive_command_checker
   import dcsm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_opcode,
   input  logic [TIME_WIDTH-1:0]         req_time_ms,
   input  logic signed [VALUE_WIDTH-1:0] req_first_value,
   input  logic signed [VALUE_WIDTH-1:0] req_second_value,
   input  logic                          req_solver_ok,
   input  logic [BUTTON_MAX-1:0]         req_buttons,
   input  logic [COUNT_WIDTH-1:0]        req_button_count,
   input  logic                          req_trailing,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_command_kind,
   input  logic signed [VALUE_WIDTH-1:0] rsp_out_first,
   input  logic signed [VALUE_WIDTH-1:0] rsp_out_second,
   output int                            failures,
   output int                            pending
);

   logic signed [COUNT_WIDTH-1:0] toggle_index;
   logic [DWELL_WIDTH-1:0]        dwell_ms;
   logic [COUNT_WIDTH-1:0]        stable_len;

   mode_type                      drive_mode;
   logic [TIME_WIDTH-1:0]         dwell_end;
   logic [HISTORY_MAX-1:0]        ok_bits;
   logic [COUNT_WIDTH-1:0]        ok_count;
   logic                          planner_valid;
   logic                          tracker_valid;
   logic                          joy_primed;
   logic signed [VALUE_WIDTH-1:0] duty;
   logic signed [VALUE_WIDTH-1:0] servo;
   logic signed [VALUE_WIDTH-1:0] steer;
   logic signed [VALUE_WIDTH-1:0] speed;
   logic [BUTTON_MAX-1:0]         last_buttons;
   logic [COUNT_WIDTH-1:0]        last_count;

   rsp_item_type expected_commands[$];
   int mismatches = 0;

   function automatic rsp_item_type command(input kind_type kind,
                                            input logic signed [VALUE_WIDTH-1:0] a,
                                            input logic signed [VALUE_WIDTH-1:0] b);
      rsp_item_type cmd;
      cmd.command_kind = kind;
      cmd.out_first    = a;
      cmd.out_second   = b;
      return cmd;
   endfunction

   // append at the tail of the expected queue
   function automatic void expect_command(input rsp_item_type cmd);
      expected_commands.insert(expected_commands.size(), cmd);
   endfunction

   function automatic int history_needed();
      return (stable_len > HISTORY_MAX) ? HISTORY_MAX : int'(stable_len);
   endfunction

   // buttons past the reported count read as released
   function automatic logic button_down(input logic [BUTTON_MAX-1:0] bits,
                                        input logic [COUNT_WIDTH-1:0] count,
                                        input logic signed [COUNT_WIDTH-1:0] index);
      int present;
      present = (count > BUTTON_MAX) ? BUTTON_MAX : int'(count);
      if (index < 0 || int'(index) >= present) return 1'b0;
      return bits[int'(index)];
   endfunction

   function automatic logic planner_is_stable();
      logic [HISTORY_MAX-1:0] held;
      held = ~({HISTORY_MAX{1'b1}} << ok_count);
      return planner_valid && int'(ok_count) >= history_needed() && (ok_bits & held) == held;
   endfunction

   task automatic predict_command(input req_item_type item);
      logic                  now_down;
      logic                  was_down;
      logic [TIME_WIDTH-1:0] since;
      case (item.opcode)
         OP_PLANNER: begin
            duty          = item.first_value;
            servo         = item.second_value;
            planner_valid = 1'b1;
            ok_bits       = {ok_bits[HISTORY_MAX-2:0], item.solver_ok};
            if (ok_count < HISTORY_MAX) ok_count++;
            // drop the oldest entry once past the required length
            if (int'(ok_count) > history_needed()) ok_count--;
         end
         OP_TRACKER: begin
            steer         = item.first_value;
            speed         = item.second_value;
            tracker_valid = 1'b1;
         end
         OP_JOYSTICK: begin
            if (joy_primed) begin
               now_down = button_down(item.buttons, item.button_count, toggle_index);
               was_down = button_down(last_buttons, last_count, toggle_index);
               if (now_down && !was_down) begin
                  if (drive_mode == MODE_AUTO) begin
                     drive_mode = MODE_ARMING;
                     dwell_end  = item.time_ms + TIME_WIDTH'(dwell_ms);
                  end else begin
                     drive_mode = MODE_AUTO;
                  end
               end
            end
            joy_primed   = 1'b1;
            last_buttons = item.buttons;
            last_count   = item.button_count;
         end
         OP_TICK: begin
            if (drive_mode == MODE_ARMING) begin
               since = item.time_ms - dwell_end;
               if (since[TIME_WIDTH-1])
                  expect_command(command(KIND_STOP, '0, '0));
               else
                  drive_mode = MODE_JOY;
            end else if (drive_mode == MODE_AUTO) begin
               if (!item.trailing && planner_is_stable())
                  expect_command(command(KIND_LOW_LEVEL, duty, servo));
               else if (tracker_valid)
                  expect_command(command(KIND_DRIVE, steer, speed));
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(input string what, input rsp_item_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                  $time, what, want.command_kind, want.out_first, want.out_second,
                  rsp_command_kind, rsp_out_first, rsp_out_second);
   endtask

   always @(posedge clock) begin
      req_item_type item;
      rsp_item_type want;
      if (reset) begin
         toggle_index  = TOGGLE_BUTTON_RESET;
         dwell_ms      = STOP_DWELL_RESET;
         stable_len    = STABILITY_RESET;
         drive_mode    = MODE_AUTO;
         dwell_end     = '0;
         ok_bits       = '0;
         ok_count      = '0;
         planner_valid = 1'b0;
         tracker_valid = 1'b0;
         joy_primed    = 1'b0;
         duty          = '0;
         servo         = '0;
         steer         = '0;
         speed         = '0;
         last_buttons  = '0;
         last_count    = '0;
         expected_commands.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TOGGLE_BUTTON: toggle_index = csr_write_data[COUNT_WIDTH-1:0];
               CSR_STOP_DWELL:    dwell_ms     = csr_write_data[DWELL_WIDTH-1:0];
               CSR_STABILITY:     stable_len   = csr_write_data[COUNT_WIDTH-1:0];
               default: ;
            endcase
         end
         // retire the response first: a tick accepted now cannot be answered now
         if (rsp_valid && !rsp_stall) begin
            if (expected_commands.size() == 0) begin
               note_mismatch("unexpected command", command(KIND_STOP, '0, '0));
            end else begin
               want = expected_commands[0];
               expected_commands.delete(0);
               if (want.command_kind !== rsp_command_kind || want.out_first !== rsp_out_first ||
                   want.out_second !== rsp_out_second)
                  note_mismatch("command mismatch", want);
            end
         end
         if (req_valid && !req_stall) begin
            item.opcode       = opcode_type'(req_opcode);
            item.time_ms      = req_time_ms;
            item.first_value  = req_first_value;
            item.second_value = req_second_value;
            item.solver_ok    = req_solver_ok;
            item.buttons      = req_buttons;
            item.button_count = req_button_count;
            item.trailing     = req_trailing;
            predict_command(item);
         end
      end
      failures <= mismatches;
      pending  <= expected_commands.size();
   end

endmodule

// ===== tb/drive_command_source_mux_unit_tb.sv =====
`timescale 1ns / 100ps

module drive_command_source_mux_unit_tb;
   import dcsm_pkg::*;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index        = CSR_TOGGLE_BUTTON;
   logic [CSR_DATA_WIDTH-1:0]     csr_write_data   = '0;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_opcode       = '0;
   logic [TIME_WIDTH-1:0]         req_time_ms      = '0;
   logic signed [VALUE_WIDTH-1:0] req_first_value  = '0;
   logic signed [VALUE_WIDTH-1:0] req_second_value = '0;
   logic                          req_solver_ok    = 1'b0;
   logic [BUTTON_MAX-1:0]         req_buttons      = '0;
   logic [COUNT_WIDTH-1:0]        req_button_count = '0;
   logic                          req_trailing     = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic [1:0]                    rsp_command_kind;
   logic signed [VALUE_WIDTH-1:0] rsp_out_first;
   logic signed [VALUE_WIDTH-1:0] rsp_out_second;
   int                            failures;
   int                            pending;

   int                            stall_pct = 0;
   int                            stall_run = 0;
   int                            gap_pct   = 0;
   int unsigned                   now_ms    = 0;
   logic signed [COUNT_WIDTH-1:0] toggle_cfg = TOGGLE_BUTTON_RESET;
   logic                          joy_press = 1'b0;

   drive_command_source_mux_unit i_dut (.*);

   drive_command_checker i_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("drive_command_source_mux_unit_tb: done, errors");
      $finish;
   end

   // response back-pressure: runs of stall, mostly short, now and then long
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct) begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b1;
         stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
   end

   function automatic int pick_gap();
      if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
   endfunction

   task automatic send(input req_item_type item);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode       <= item.opcode;
      req_time_ms      <= item.time_ms;
      req_first_value  <= item.first_value;
      req_second_value <= item.second_value;
      req_solver_ok    <= item.solver_ok;
      req_buttons      <= item.buttons;
      req_button_count <= item.button_count;
      req_trailing     <= item.trailing;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every expected command is back, then let the pipeline empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_config(input logic signed [COUNT_WIDTH-1:0] button,
                                 input logic [DWELL_WIDTH-1:0] dwell,
                                 input logic [COUNT_WIDTH-1:0] length);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TOGGLE_BUTTON;
      csr_write_data   <= {11'($urandom), button};
      @(posedge clock);
      csr_index        <= CSR_STOP_DWELL;
      csr_write_data   <= dwell;
      @(posedge clock);
      csr_index        <= CSR_STABILITY;
      csr_write_data   <= {11'($urandom), length};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      toggle_cfg = button;
   endtask

   function automatic req_item_type event_item(input opcode_type op, input logic [31:0] t,
                                               input int a, input int b, input logic ok,
                                               input logic [15:0] buttons, input int count,
                                               input logic trailing);
      req_item_type item;
      item.opcode       = op;
      item.time_ms      = t;
      item.first_value  = 16'(a);
      item.second_value = 16'(b);
      item.solver_ok    = ok;
      item.buttons      = buttons;
      item.button_count = 5'(count);
      item.trailing     = trailing;
      return item;
   endfunction

   function automatic req_item_type random_event();
      req_item_type item;
      int roll;
      item.opcode       = opcode_type'(2'($urandom));
      item.first_value  = 16'($urandom);
      item.second_value = 16'($urandom);
      item.solver_ok    = 1'($urandom);
      item.buttons      = 16'($urandom);
      item.button_count = 5'($urandom_range(0, 31));
      item.trailing     = 1'($urandom);
      if ($urandom_range(0, 19) == 0)
         now_ms += $urandom_range(1000, 70000);
      else
         now_ms += $urandom_range(0, 40);
      item.time_ms = now_ms;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         item.time_ms = $urandom;
         return item;
      end
      if (roll < 45) begin
         item.opcode   = OP_TICK;
         item.trailing = ($urandom_range(0, 4) == 0);
      end else if (roll < 70) begin
         item.opcode    = OP_PLANNER;
         item.solver_ok = ($urandom_range(0, 9) != 0);
      end else if (roll < 82) begin
         item.opcode = OP_TRACKER;
      end else begin
         // press and release the toggle button with the rest of the pad random
         item.opcode = OP_JOYSTICK;
         if ($urandom_range(0, 2) != 0) joy_press = ~joy_press;
         if ($urandom_range(0, 9) != 0) item.button_count = 5'(BUTTON_MAX);
         if (toggle_cfg >= 0) item.buttons[int'(toggle_cfg)] = joy_press;
      end
      return item;
   endfunction

   initial begin
      logic signed [COUNT_WIDTH-1:0] button;
      logic [DWELL_WIDTH-1:0]        dwell;
      logic [COUNT_WIDTH-1:0]        length;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      gap_pct    = 20;
      stall_pct <= 20;
      send(event_item(OP_TICK,     32'd0,    0,      0,      1'b1, 16'h0000, 16, 1'b0));
      send(event_item(OP_TRACKER,  32'd1000, 32767,  -32768, 1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_TICK,     32'd1001, 0,      0,      1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_PLANNER,  32'd1002, 0,      0,      1'b1, 16'h0000, 0,  1'b0));
      send(event_item(OP_PLANNER,  32'd1003, 1,      -1,     1'b1, 16'h0000, 0,  1'b0));
      send(event_item(OP_PLANNER,  32'd1004, 100,    200,    1'b1, 16'h0000, 0,  1'b0));
      send(event_item(OP_PLANNER,  32'd1005, 32767,  -32768, 1'b1, 16'h0000, 0,  1'b0));
      send(event_item(OP_TICK,     32'd1006, 0,      0,      1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_PLANNER,  32'd1007, -32768, 32767,  1'b1, 16'h0000, 0,  1'b0));
      send(event_item(OP_TICK,     32'd1008, 0,      0,      1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_TICK,     32'd1009, 0,      0,      1'b0, 16'h0000, 0,  1'b1));
      send(event_item(OP_PLANNER,  32'd1010, 7,      7,      1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_TICK,     32'd1011, 0,      0,      1'b0, 16'h0000, 0,  1'b0));
      // first pad sample only primes the edge detector
      send(event_item(OP_JOYSTICK, 32'd2000, 0,      0,      1'b0, 16'h0020, 16, 1'b0));
      send(event_item(OP_JOYSTICK, 32'd2010, 0,      0,      1'b0, 16'h0000, 16, 1'b0));
      send(event_item(OP_JOYSTICK, 32'd2020, 0,      0,      1'b0, 16'hFFFF, 16, 1'b0));
      send(event_item(OP_TICK,     32'd2319, 0,      0,      1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_TICK,     32'd2320, 0,      0,      1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_TICK,     32'd2500, 0,      0,      1'b0, 16'h0000, 0,  1'b0));
      send(event_item(OP_JOYSTICK, 32'd2600, 0,      0,      1'b0, 16'h0000, 16, 1'b0));
      // pressed but past the count: no edge
      send(event_item(OP_JOYSTICK, 32'd2610, 0,      0,      1'b0, 16'hFFFF, 5,  1'b0));
      // count above the pad size saturates
      send(event_item(OP_JOYSTICK, 32'd2620, 0,      0,      1'b0, 16'h0020, 31, 1'b0));
      send(event_item(OP_TICK,     32'hFFFF_FFFF, 0, 0,      1'b0, 16'h0000, 0,  1'b0));
      wait_idle();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin button = 5;   dwell = 300;   length = 5;  now_ms = 5000;         end
            1: begin button = -1;  dwell = 0;     length = 0;  now_ms = 0;            end
            2: begin button = 15;  dwell = 65535; length = 16; now_ms = 32'hFFFF_0000; end
            3: begin button = 0;   dwell = 0;     length = 31; now_ms = 123;          end
            4: begin button = -16; dwell = 100;   length = 1;  now_ms = $urandom;     end
            5: begin button = 3;   dwell = 1;     length = 2;  now_ms = 32'hFFFF_FFC0; end
            default: begin
               button = 5'($urandom_range(0, 31));
               case ($urandom_range(0, 3))
                  0:       dwell = 0;
                  1:       dwell = 16'hFFFF;
                  default: dwell = 16'($urandom_range(0, 2000));
               endcase
               length = 5'($urandom_range(0, 31));
               now_ms = $urandom;
            end
         endcase
         program_config(button, dwell, length);
         // phase 1 runs with no idling on either side
         gap_pct    = (phase == 1) ? 0 : $urandom_range(10, 50);
         stall_pct <= (phase == 1) ? 0 : $urandom_range(10, 60);
         for (int n = 0; n < 175; n++) begin
            if (n == 87) wait_idle();
            send(random_event());
         end
         wait_idle();
      end

      if (failures == 0 && pending == 0)
         $display("drive_command_source_mux_unit_tb: done, clean");
      else
         $display("drive_command_source_mux_unit_tb: done, errors");
      $finish;
   end

endmodule

// ===== drive_command_source_mux_unit.f =====
rtl/dcsm_pkg.sv
rtl/dcsm_in_stage.sv
rtl/dcsm_core.sv
rtl/dcsm_out_stage.sv
rtl/drive_command_source_mux_unit.sv
tb/drive_command_checker.sv
tb/drive_command_source_mux_unit_tb.sv
